// ===== design/stereo_lfo_flanger_macros.svh =====
// Assertion shorthands for the flanger top level.
`ifndef STEREO_LFO_FLANGER_MACROS_SVH
`define STEREO_LFO_FLANGER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define SLF_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define SLF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/slfl_pkg.sv =====
package slfl_pkg;

  localparam int ACC_W = 44;

  localparam logic [16:0] GAIN_ONE = 17'h10000;

  // register indexes on the config port
  localparam logic [2:0] REG_LFO_STEP   = 3'd0;
  localparam logic [2:0] REG_DEPTH      = 3'd1;
  localparam logic [2:0] REG_BASE_DELAY = 3'd2;
  localparam logic [2:0] REG_FEEDBACK   = 3'd3;
  localparam logic [2:0] REG_WIDTH_OFS  = 3'd4;
  localparam logic [2:0] REG_MIX        = 3'd5;
  localparam logic [2:0] REG_BYPASS     = 3'd6;

  // register reset values
  localparam logic [30:0] RST_LFO_STEP   = 31'd44739;
  localparam logic [16:0] RST_DEPTH      = 17'd32768;
  localparam logic [18:0] RST_BASE_DELAY = 19'd36864;
  localparam logic [16:0] RST_FEEDBACK   = 17'd19661;
  localparam logic [31:0] RST_WIDTH_OFS  = 32'h8000_0000;
  localparam logic [16:0] RST_MIX        = 17'd32768;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADDR,
    ST_DEP,
    ST_W1,
    ST_BASE,
    ST_W2,
    ST_DLY,
    ST_RDA,
    ST_RDB,
    ST_MB,
    ST_W3,
    ST_MIX,
    ST_MIX2,
    ST_W4,
    ST_FB,
    ST_W5,
    ST_WR,
    ST_DONE
  } state_t;

  // one request to the shared multiply-accumulate unit
  typedef struct packed {
    logic               go;
    logic               clr;
    logic signed [24:0] a;
    logic signed [17:0] b;
    logic        [16:0] bias;
  } mac_op_t;

  // sin(pi/2*(k+0.5)/2^bits) in Q0.15, Q30 Taylor evaluation, elaboration only
  function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    a  = ((64'(2 * k + 1)) * 64'd1686629713) >> (bits + 1);
    a2 = (a * a) >> 30;
    t  = 64'd1073741824;
    t  = 64'd1073741824 - (((a2 * t) >> 30) / 64'd110);
    t  = 64'd1073741824 - (((a2 * t) >> 30) / 64'd72);
    t  = 64'd1073741824 - (((a2 * t) >> 30) / 64'd42);
    t  = 64'd1073741824 - (((a2 * t) >> 30) / 64'd20);
    t  = 64'd1073741824 - (((a2 * t) >> 30) / 64'd6);
    s  = (a * t) >> 30;
    v  = (s + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

// ===== design/slfl_ram.sv =====
module slfl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/slfl_mac.sv =====
module slfl_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  slfl_pkg::mac_op_t                op,
  output logic signed [slfl_pkg::ACC_W-1:0] acc
);
  import slfl_pkg::*;

  // stage 1: product, stage 2: accumulate (or restart from bias)
  logic signed [42:0]      prod_r;
  logic                    go_r;
  logic                    clr_r;
  logic [16:0]             bias_r;
  logic signed [ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
    end else begin
      go_r <= op.go;
    end
  end

  always_ff @(posedge clk) begin
    if (op.go) begin
      prod_r <= op.a * op.b;
      clr_r  <= op.clr;
      bias_r <= op.bias;
    end
    if (go_r) begin
      acc_r <= (clr_r ? $signed({27'd0, bias_r}) : acc_r) + {prod_r[42], prod_r};
    end
  end

  assign acc = acc_r;

endmodule

// ===== design/slfl_sine.sv =====
module slfl_sine #(
  parameter int ROM_BITS = 10
) (
  input  logic        clk,
  input  logic [31:0] phase,
  output logic [14:0] mag,
  output logic        neg
);
  import slfl_pkg::*;

  localparam int RomSize = 1 << ROM_BITS;

  logic [14:0]         tbl [RomSize];
  logic [ROM_BITS-1:0] idx;
  logic [14:0]         mag_r;
  logic                neg_r;

  for (genvar k = 0; k < RomSize; k++) begin : g_tbl
    localparam logic [14:0] EntryV = sine_entry(k, ROM_BITS);
    assign tbl[k] = EntryV;
  end

  // odd quadrants run the quarter wave backwards
  assign idx = phase[30] ? ~phase[29 -: ROM_BITS] : phase[29 -: ROM_BITS];

  always_ff @(posedge clk) begin
    mag_r <= tbl[idx];
    neg_r <= phase[31];
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

// ===== design/stereo_lfo_flanger.sv =====
// Frames are taken only in ST_IDLE: a new frame waits until the last result has left
// ST_DONE, which out_stall can hold. Bypass goes from ST_IDLE straight to ST_DONE; else each
// channel runs 16 sequencer steps through the one two-stage multiply-accumulate unit.
// Reset (synchronous, rst_n low): config to defaults, LFO phase and write slot
// to zero. History stores are not swept: entries not yet written since reset
// read as zero, tracked by the write slot and a wrap flag.
`include "stereo_lfo_flanger_macros.svh"

module stereo_lfo_flanger #(
  parameter int DELAY_DEPTH   = 2048,
  parameter int SINE_ROM_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  // input requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_left_in,
  input  logic signed [23:0] in_right_in,
  // result requests
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_left_out,
  output logic signed [23:0] out_right_out,
  // config writes
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata
);
  import slfl_pkg::*;

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int AW1 = AW + 1;
  localparam logic [24:0]   DMax     = 25'((DELAY_DEPTH - 1) * 256);
  localparam logic [24:0]   DMin     = 25'd256;
  localparam logic [AW1-1:0] DepthW  = AW1'(DELAY_DEPTH);
  localparam logic [AW-1:0]  LastSlot = AW'(DELAY_DEPTH - 1);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [30:0] step_r;
  logic [16:0] depth_r;
  logic [18:0] base_r;
  logic [16:0] fbk_r;
  logic [31:0] width_r;
  logic [16:0] mix_r;
  logic        bypass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= RST_LFO_STEP;
      depth_r  <= RST_DEPTH;
      base_r   <= RST_BASE_DELAY;
      fbk_r    <= RST_FEEDBACK;
      width_r  <= RST_WIDTH_OFS;
      mix_r    <= RST_MIX;
      bypass_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LFO_STEP:   step_r   <= cfg_wdata[30:0];
        REG_DEPTH:      depth_r  <= cfg_wdata[16:0];
        REG_BASE_DELAY: base_r   <= cfg_wdata[18:0];
        REG_FEEDBACK:   fbk_r    <= cfg_wdata[16:0];
        REG_WIDTH_OFS:  width_r  <= cfg_wdata;
        REG_MIX:        mix_r    <= cfg_wdata[16:0];
        REG_BYPASS:     bypass_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // gains above unity are held at unity
  logic [16:0] depth_c;
  logic [16:0] fbk_c;
  logic [16:0] mix_c;

  assign depth_c = (depth_r > GAIN_ONE) ? GAIN_ONE : depth_r;
  assign fbk_c   = (fbk_r > GAIN_ONE) ? GAIN_ONE : fbk_r;
  assign mix_c   = (mix_r > GAIN_ONE) ? GAIN_ONE : mix_r;

  // ---------------------------------------------------------------------------
  // Sequencer state and working registers
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic               ch_r;       // 0 left, 1 right
  logic signed [23:0] xl_r;
  logic signed [23:0] xr_r;
  logic signed [23:0] yl_r;
  logic signed [23:0] yr_r;
  logic [31:0]        phase_r;
  logic [AW-1:0]      ws_r;       // write slot
  logic               wrap_r;     // every slot written at least once
  logic [AW-1:0]      di_r;       // integer delay
  logic [7:0]         frac_r;     // fractional delay
  logic [AW-1:0]      ib_r;
  logic               va_r;
  logic               vb_r;
  logic signed [23:0] dly_r;      // interpolated delayed sample
  logic               out_valid_r;
  logic signed [23:0] out_left_r;
  logic signed [23:0] out_right_r;

  logic                    accept;
  logic                    out_load;
  logic signed [23:0]      x_cur;
  logic [31:0]             ph_sel;
  logic [14:0]             sin_mag;
  logic                    sin_neg;
  logic [15:0]             lfo_u;
  mac_op_t                 mac_op;
  logic signed [ACC_W-1:0] acc;
  logic [24:0]             d_sum;
  logic [24:0]             d_cl;
  logic [AW1-1:0]          ia_sum;
  logic [AW-1:0]           ia;
  logic [AW-1:0]           raddr;
  logic signed [23:0]      rq_l;
  logic signed [23:0]      rq_r;
  logic signed [23:0]      ram_q;
  logic signed [23:0]      samp;
  logic signed [23:0]      y_cur;
  logic signed [23:0]      wr_val;
  logic                    we_l;
  logic                    we_r;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign x_cur    = ch_r ? xr_r : xl_r;

  // right channel sees the LFO shifted by the stereo width
  assign ph_sel = ch_r ? (phase_r + width_r) : phase_r;

  slfl_sine #(
    .ROM_BITS (SINE_ROM_BITS)
  ) u_sine (
    .clk   (clk),
    .phase (ph_sel),
    .mag   (sin_mag),
    .neg   (sin_neg)
  );

  // LFO lifted to 1..65535 (Q0.16)
  assign lfo_u = sin_neg ? (16'h8000 - {1'b0, sin_mag}) : (16'h8000 + {1'b0, sin_mag});

  slfl_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .acc   (acc)
  );

  // delay in Q.8 samples, clamped to one sample .. depth-1 samples
  assign d_sum = 25'(base_r) + 25'(acc[34:16]);
  assign d_cl  = (d_sum < DMin) ? DMin : ((d_sum > DMax) ? DMax : d_sum);

  // slot written di frames ago, modulo the store depth
  assign ia_sum = AW1'(ws_r) + DepthW - AW1'(di_r);
  assign ia     = (ia_sum >= DepthW) ? AW'(ia_sum - DepthW) : ia_sum[AW-1:0];

  assign raddr = (state_r == ST_RDA) ? ia : ib_r;

  slfl_ram #(
    .WIDTH (24),
    .DEPTH (DELAY_DEPTH)
  ) u_hist_l (
    .clk   (clk),
    .we    (we_l),
    .waddr (ws_r),
    .wdata (wr_val),
    .raddr (raddr),
    .rdata (rq_l)
  );

  slfl_ram #(
    .WIDTH (24),
    .DEPTH (DELAY_DEPTH)
  ) u_hist_r (
    .clk   (clk),
    .we    (we_r),
    .waddr (ws_r),
    .wdata (wr_val),
    .raddr (raddr),
    .rdata (rq_r)
  );

  assign ram_q = ch_r ? rq_r : rq_l;

  // a slot not yet written since reset reads as silence
  always_comb begin
    samp = 24'sd0;
    if ((state_r == ST_RDB && va_r) || (state_r == ST_MB && vb_r)) begin
      samp = ram_q;
    end
  end

  assign y_cur  = sat24(acc[43:16]);
  assign wr_val = sat24(28'(x_cur) + acc[43:16]);
  assign we_l   = (state_r == ST_WR) && !ch_r;
  assign we_r   = (state_r == ST_WR) && ch_r;

  // ---------------------------------------------------------------------------
  // FSM: state register, then next state and MAC requests
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mac_op    = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = bypass_r ? ST_DONE : ST_ADDR;
        end
      end
      ST_ADDR: state_nxt = ST_DEP;
      ST_DEP: begin
        // m = depth * u
        mac_op.go  = 1'b1;
        mac_op.clr = 1'b1;
        mac_op.a   = 25'(lfo_u);
        mac_op.b   = 18'(depth_c);
        state_nxt  = ST_W1;
      end
      ST_W1: state_nxt = ST_BASE;
      ST_BASE: begin
        // base * (m >> 16)
        mac_op.go  = 1'b1;
        mac_op.clr = 1'b1;
        mac_op.a   = 25'(base_r);
        mac_op.b   = 18'(acc[31:16]);
        state_nxt  = ST_W2;
      end
      ST_W2:  state_nxt = ST_DLY;
      ST_DLY: state_nxt = ST_RDA;
      ST_RDA: state_nxt = ST_RDB;
      ST_RDB: begin
        // a * (256 - f) + 128
        mac_op.go   = 1'b1;
        mac_op.clr  = 1'b1;
        mac_op.a    = 25'(samp);
        mac_op.b    = 18'(9'd256 - 9'(frac_r));
        mac_op.bias = 17'd128;
        state_nxt   = ST_MB;
      end
      ST_MB: begin
        // + b * f
        mac_op.go  = 1'b1;
        mac_op.a   = 25'(samp);
        mac_op.b   = 18'(frac_r);
        state_nxt  = ST_W3;
      end
      ST_W3: state_nxt = ST_MIX;
      ST_MIX: begin
        // dry share: x * (1 - mix) + rounding
        mac_op.go   = 1'b1;
        mac_op.clr  = 1'b1;
        mac_op.a    = 25'(x_cur);
        mac_op.b    = 18'(GAIN_ONE - mix_c);
        mac_op.bias = 17'd32768;
        state_nxt   = ST_MIX2;
      end
      ST_MIX2: begin
        // wet share
        mac_op.go  = 1'b1;
        mac_op.a   = 25'(dly_r);
        mac_op.b   = 18'(mix_c);
        state_nxt  = ST_W4;
      end
      ST_W4: state_nxt = ST_FB;
      ST_FB: begin
        // feedback into the store
        mac_op.go   = 1'b1;
        mac_op.clr  = 1'b1;
        mac_op.a    = 25'(dly_r);
        mac_op.b    = 18'(fbk_c);
        mac_op.bias = 17'd32768;
        state_nxt   = ST_W5;
      end
      ST_W5: state_nxt = ST_WR;
      ST_WR: state_nxt = ch_r ? ST_DONE : ST_ADDR;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers: phase, write slot, wrap flag, channel, output valid
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 32'd0;
      ws_r        <= '0;
      wrap_r      <= 1'b0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        ch_r <= 1'b0;
      end
      if (state_r == ST_WR) begin
        if (ch_r) begin
          // frame done: advance slot and LFO
          phase_r <= phase_r + 32'(step_r);
          if (ws_r == LastSlot) begin
            ws_r   <= '0;
            wrap_r <= 1'b1;
          end else begin
            ws_r <= ws_r + 1'b1;
          end
        end else begin
          ch_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      xl_r <= in_left_in;
      xr_r <= in_right_in;
      yl_r <= in_left_in;   // bypass result; overwritten otherwise
      yr_r <= in_right_in;
    end
    case (state_r)
      ST_DLY: begin
        di_r   <= d_cl[AW+7:8];
        frac_r <= d_cl[7:0];
      end
      ST_RDA: begin
        ib_r <= (ia == '0) ? LastSlot : (ia - 1'b1);
        va_r <= wrap_r || (ia < ws_r);
      end
      ST_RDB: begin
        vb_r <= wrap_r || (ib_r < ws_r);
      end
      ST_MIX: begin
        dly_r <= acc[31:8];
      end
      ST_FB: begin
        if (ch_r) begin
          yr_r <= y_cur;
        end else begin
          yl_r <= y_cur;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_left_r  <= yl_r;
      out_right_r <= yr_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SLF_ASSERT_IMPLY(a_ws_range, clk, rst_n, 1'b1, AW1'(ws_r) < DepthW, "write slot out of range")
  `SLF_ASSERT_NEXT(a_wrap_sticky, clk, rst_n, wrap_r, wrap_r, "wrap flag cleared outside reset")
  `SLF_ASSERT_NEXT(a_bypass_frozen, clk, rst_n, accept && bypass_r,
                   $stable(phase_r) && $stable(ws_r), "bypass frame moved the state")
  `SLF_ASSERT_IMPLY(a_wr_slot_free, clk, rst_n, state_r == ST_MB,
                    ib_r != ws_r || !vb_r || wrap_r, "read of live slot before wrap")

endmodule

// ===== bench/flanger_checker.sv =====
`timescale 1ns / 100ps

module flanger_checker #(
  parameter int DELAY_DEPTH = 2048,
  parameter int ROM_BITS    = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [23:0] in_left_in,
  input  logic signed [23:0] in_right_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [23:0] out_left_out,
  input  logic signed [23:0] out_right_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 frames_pending,
  output int                 frames_checked
);

  localparam int ROM_SIZE = 1 << ROM_BITS;
  localparam int MAX_REPORTS = 10;
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint SAMPLE_MAX = 64'sd8388607;
  localparam longint SAMPLE_MIN = -64'sd8388608;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } stereo_frame_t;

  int sine_q15 [ROM_SIZE];
  int history [2][DELAY_DEPTH];

  logic [30:0] step_reg;
  logic [16:0] depth_reg;
  logic [18:0] base_reg;
  logic [16:0] fb_reg;
  logic [31:0] width_reg;
  logic [16:0] mix_reg;
  logic        bypass_reg;

  logic [31:0] lfo_phase;
  int          write_slot;

  stereo_frame_t flanged_q [$];
  int errors = 0;
  int checked = 0;

  // quarter-wave sine table, Q0.15, sampled at bin centres
  initial begin : rom_fill
    longint unsigned ang, ang2, term, s, v;
    for (int k = 0; k < ROM_SIZE; k++) begin
      ang  = (64'(2 * k + 1) * HALF_PI_Q30) >> (ROM_BITS + 1);
      ang2 = (ang * ang) >> 30;
      term = Q30_ONE;
      term = Q30_ONE - (((ang2 * term) >> 30) / 110);
      term = Q30_ONE - (((ang2 * term) >> 30) / 72);
      term = Q30_ONE - (((ang2 * term) >> 30) / 42);
      term = Q30_ONE - (((ang2 * term) >> 30) / 20);
      term = Q30_ONE - (((ang2 * term) >> 30) / 6);
      s = (ang * term) >> 30;
      v = (s + 16384) >> 15;
      if (v > 32767) begin
        v = 32767;
      end
      sine_q15[k] = int'(v);
    end
  end

  function automatic longint clamp24(input longint v);
    if (v > SAMPLE_MAX) begin
      return SAMPLE_MAX;
    end
    if (v < SAMPLE_MIN) begin
      return SAMPLE_MIN;
    end
    return v;
  endfunction

  function automatic longint gain_cap(input logic [16:0] g);
    return (g > slfl_pkg::GAIN_ONE) ? 64'sd65536 : longint'(g);
  endfunction

  function automatic longint lfo_at(input logic [31:0] ph);
    logic [ROM_BITS-1:0] idx;
    longint v;
    idx = ph[29 -: ROM_BITS];
    if (ph[30]) begin
      idx = ~idx;  // odd quadrant runs the table backwards
    end
    v = sine_q15[idx];
    return ph[31] ? -v : v;
  endfunction

  // one channel: modulated fractional tap, wet/dry blend, feedback write
  function automatic longint flange_voice(input int ch, input longint x,
                                          input logic [31:0] ph);
    longint u, m, d, dly, a, b, wet, fbv, mix;
    int di, f, ia, ib;
    u = lfo_at(ph) + 32768;
    m = (gain_cap(depth_reg) * u) >>> 16;
    d = base_reg;
    d = d + ((d * m) >>> 16);
    if (d < 256) begin
      d = 256;
    end
    if (d > (DELAY_DEPTH - 1) * 256) begin
      d = (DELAY_DEPTH - 1) * 256;
    end
    di = int'(d >>> 8);
    f  = int'(d & 255);
    ia = (write_slot + DELAY_DEPTH - di) % DELAY_DEPTH;
    ib = (write_slot + 2 * DELAY_DEPTH - di - 1) % DELAY_DEPTH;
    a = history[ch][ia];
    b = history[ch][ib];
    dly = (a * (256 - f) + b * f + 128) >>> 8;
    mix = gain_cap(mix_reg);
    wet = (x * (65536 - mix) + dly * mix + 32768) >>> 16;
    fbv = (dly * gain_cap(fb_reg) + 32768) >>> 16;
    history[ch][write_slot] = int'(clamp24(x + fbv));
    return clamp24(wet);
  endfunction

  always @(posedge clk) begin : watch
    stereo_frame_t want;
    longint yl, yr;
    if (!rst_n) begin
      step_reg   = slfl_pkg::RST_LFO_STEP;
      depth_reg  = slfl_pkg::RST_DEPTH;
      base_reg   = slfl_pkg::RST_BASE_DELAY;
      fb_reg     = slfl_pkg::RST_FEEDBACK;
      width_reg  = slfl_pkg::RST_WIDTH_OFS;
      mix_reg    = slfl_pkg::RST_MIX;
      bypass_reg = 1'b0;
      lfo_phase  = '0;
      write_slot = 0;
      for (int c = 0; c < 2; c++) begin
        for (int s = 0; s < DELAY_DEPTH; s++) begin
          history[c][s] = 0;
        end
      end
      flanged_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          slfl_pkg::REG_LFO_STEP:   step_reg   = cfg_wdata[30:0];
          slfl_pkg::REG_DEPTH:      depth_reg  = cfg_wdata[16:0];
          slfl_pkg::REG_BASE_DELAY: base_reg   = cfg_wdata[18:0];
          slfl_pkg::REG_FEEDBACK:   fb_reg     = cfg_wdata[16:0];
          slfl_pkg::REG_WIDTH_OFS:  width_reg  = cfg_wdata;
          slfl_pkg::REG_MIX:        mix_reg    = cfg_wdata[16:0];
          slfl_pkg::REG_BYPASS:     bypass_reg = cfg_wdata[0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (bypass_reg) begin
          want.left  = in_left_in;
          want.right = in_right_in;
        end else begin
          yl = flange_voice(0, in_left_in, lfo_phase);
          yr = flange_voice(1, in_right_in, lfo_phase + width_reg);
          write_slot = (write_slot + 1) % DELAY_DEPTH;
          lfo_phase  = lfo_phase + step_reg;
          want.left  = yl[23:0];
          want.right = yr[23:0];
        end
        flanged_q.insert(flanged_q.size(), want);
      end

      if (out_valid && !out_stall) begin
        if (flanged_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: unexpected result request L=%0d R=%0d", $realtime,
                     out_left_out, out_right_out);
          end
        end else begin
          want = flanged_q.pop_front();
          checked++;
          if (out_left_out !== want.left || out_right_out !== want.right) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: frame %0d mismatch L exp %0d got %0d, R exp %0d got %0d",
                       $realtime, checked, $signed(want.left), out_left_out,
                       $signed(want.right), out_right_out);
            end
          end
        end
      end
    end
    fail_count     <= errors;
    frames_pending <= flanged_q.size();
    frames_checked <= checked;
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  // idle time after the last result, before touching config
  localparam int SETTLE_CYCLES    = 40;
  localparam int RANDOM_PHASES    = 14;
  localparam int FRAMES_PER_PHASE = 125;
  localparam int IDLE_PERCENT     = 19;
  localparam logic [2:0] REG_SPARE = 3'd7;  // no register behind this index

  localparam logic signed [23:0] S24_TOP    = 24'sh7FFFFF;
  localparam logic signed [23:0] S24_BOTTOM = 24'sh800000;

  // shapes of the random audio content
  typedef enum int {
    SIG_NOISE,
    SIG_QUIET,
    SIG_RAILS,
    SIG_DRIFT
  } signal_style_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [23:0] in_left_in = '0;
  logic signed [23:0] in_right_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [23:0] out_left_out;
  logic signed [23:0] out_right_out;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_addr = '0;
  logic [31:0]        cfg_wdata = '0;

  logic calm = 1'b0;  // high: neither side idles
  int   fail_count;
  int   frames_pending;
  int   frames_checked;
  int   settings_used = 0;
  int   bypass_runs = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  stereo_lfo_flanger DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  flanger_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_left_in     (in_left_in),
    .in_right_in    (in_right_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_out   (out_left_out),
    .out_right_out  (out_right_out),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .frames_pending (frames_pending),
    .frames_checked (frames_checked)
  );

  // Result side back-pressure: a fresh coin each cycle, so stalls land on
  // every step of the sequencer, except during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Fill the bits above a register's width with junk; the block must mask them.
  function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
    if (w >= 32) begin
      return v;
    end
    return (v & ~({32{1'b1}} << w)) | ($urandom << w);
  endfunction

  // Gain picker shared by depth, feedback and mix: off, full, over full, anywhere.
  function automatic logic [31:0] pick_gain();
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return 32'd65536;
      2:       return $urandom_range(131071, 65537);
      default: return $urandom_range(65536);
    endcase
  endfunction

  function automatic logic signed [23:0] pick_sample(input signal_style_t style,
                                                     input logic signed [23:0] prev);
    int v;
    case (style)
      SIG_NOISE: return 24'($urandom);
      SIG_QUIET: begin
        v = $urandom_range(8191);
        return 24'(v - 4096);
      end
      SIG_RAILS: begin
        v = $urandom_range(2);
        return (v == 0) ? S24_TOP : (v == 1) ? S24_BOTTOM : 24'sd0;
      end
      default: begin
        // slow wander, wraps freely at the rails
        v = $urandom_range(2047);
        return prev + 24'(v - 1024);
      end
    endcase
  endfunction

  // Register write; cfg_we stays up so back-to-back writes never drop it mid-step.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic close_cfg();
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Offer one frame; random idle gaps before it unless calm. Returns at the
  // first edge at which in_stall is low again, leaving in_valid up for the next one.
  task automatic push_frame(input logic signed [23:0] l, input logic signed [23:0] r);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_left_in  <= l;
    in_right_in <= r;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Let every outstanding result come home, then hold the inputs idle for a
  // settle time before any register changes.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic shuffle_settings();
    logic [31:0] v;
    case ($urandom_range(3))
      0:       v = 32'd0;
      1:       v = 32'h7FFF_FFFF;
      2:       v = $urandom_range(2_000_000);
      default: v = $urandom;
    endcase
    write_reg(slfl_pkg::REG_LFO_STEP, with_junk(v, 31));
    write_reg(slfl_pkg::REG_DEPTH, with_junk(pick_gain(), 17));
    // mostly delays that sit well inside the store, some that hit the clamps
    case ($urandom_range(7))
      0:       v = 32'd0;
      1:       v = 32'd256;
      2:       v = 32'd524287;
      3, 4, 5: v = $urandom_range(16384, 256);
      default: v = $urandom_range(262000);
    endcase
    write_reg(slfl_pkg::REG_BASE_DELAY, with_junk(v, 19));
    write_reg(slfl_pkg::REG_FEEDBACK, with_junk(pick_gain(), 17));
    case ($urandom_range(3))
      0:       v = 32'd0;
      1:       v = 32'h8000_0000;
      2:       v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    write_reg(slfl_pkg::REG_WIDTH_OFS, v);
    write_reg(slfl_pkg::REG_MIX, with_junk(pick_gain(), 17));
    v = 32'($urandom_range(7) == 0);
    bypass_runs += v;
    write_reg(slfl_pkg::REG_BYPASS, with_junk(v, 1));
    if ($urandom_range(3) == 0) begin
      write_reg(REG_SPARE, $urandom);
    end
    close_cfg();
  endtask

  initial begin : stimulus
    signal_style_t style;
    logic signed [23:0] l;
    logic signed [23:0] r;
    l = '0;
    r = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults, stores still empty: full-scale and sign-boundary frames.
    push_frame(S24_TOP, S24_TOP);
    push_frame(S24_BOTTOM, S24_BOTTOM);
    push_frame(S24_TOP, S24_BOTTOM);
    push_frame(S24_BOTTOM, S24_TOP);
    push_frame(24'sd0, 24'sd0);
    push_frame(-24'sd1, 24'sd1);
    push_frame(24'sd1, -24'sd1);
    push_frame(24'sh555555, 24'shAAAAAA);
    drain();

    // Gains written above full scale, zero base delay so the tap clamps to
    // one sample; full feedback drives the store into saturation.
    write_reg(slfl_pkg::REG_DEPTH, 32'hFFFF_FFFF);
    write_reg(slfl_pkg::REG_FEEDBACK, with_junk(32'h1FFFF, 17));
    write_reg(slfl_pkg::REG_MIX, with_junk(32'h1FFFF, 17));
    write_reg(slfl_pkg::REG_BASE_DELAY, with_junk(32'd0, 19));
    write_reg(REG_SPARE, $urandom);
    close_cfg();
    push_frame(S24_TOP, S24_BOTTOM);
    push_frame(S24_TOP, S24_BOTTOM);
    push_frame(S24_TOP, S24_BOTTOM);
    push_frame(S24_BOTTOM, S24_TOP);
    push_frame(S24_BOTTOM, S24_TOP);
    push_frame(24'sd0, 24'sd0);
    drain();

    // Base delay far past the store (upper clamp), fastest LFO, no stereo
    // offset, fully wet output.
    write_reg(slfl_pkg::REG_BASE_DELAY, 32'hFFFF_FFFF);
    write_reg(slfl_pkg::REG_LFO_STEP, 32'hFFFF_FFFF);
    write_reg(slfl_pkg::REG_WIDTH_OFS, 32'd0);
    write_reg(slfl_pkg::REG_MIX, 32'd65536);
    write_reg(slfl_pkg::REG_DEPTH, 32'd65536);
    write_reg(slfl_pkg::REG_FEEDBACK, 32'd0);
    close_cfg();
    push_frame(24'sd123456, -24'sd654321);
    push_frame(S24_TOP, 24'sd0);
    push_frame(24'sd0, S24_BOTTOM);
    push_frame(-24'sd7, 24'sd7);
    push_frame(24'sh00FFFF, 24'shFF0000);
    drain();

    // Bypass: straight through, history and LFO frozen.
    write_reg(slfl_pkg::REG_BYPASS, with_junk(32'd1, 1));
    close_cfg();
    bypass_runs++;
    push_frame(S24_TOP, S24_BOTTOM);
    push_frame(24'sd0, -24'sd1);
    push_frame(24'sh3C3C3C, 24'shC3C3C3);
    push_frame(S24_BOTTOM, S24_TOP);
    drain();

    // Random settings, each held for a batch of frames. Two batches in the
    // middle run with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm <= (p == 5 || p == 6);
      shuffle_settings();
      style = signal_style_t'($urandom_range(3));
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        l = pick_sample(style, l);
        r = pick_sample(style, r);
        push_frame(l, r);
      end
      drain();
    end

    $display("Run covered %0d frames across %0d register settings (%0d bypassed).",
             frames_checked, settings_used, bypass_runs);
    if (fail_count == 0 && frames_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("Timed out with %0d frames outstanding.", frames_pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/slfl_pkg.sv
design/slfl_ram.sv
design/slfl_mac.sv
design/slfl_sine.sv
design/stereo_lfo_flanger.sv
bench/flanger_checker.sv
bench/tb_top.sv
